// ===== hdl/mtt_pkg.sv =====
package mtt_pkg;

  // Character codes the tokenizer reacts to.
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_SQUOTE = 8'd39;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_RPAREN = 8'd41;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_LT     = 8'd60;
  localparam logic [7:0] CH_EQ     = 8'd61;
  localparam logic [7:0] CH_GT     = 8'd62;
  localparam logic [7:0] CH_LBRACK = 8'd91;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_RBRACK = 8'd93;
  localparam logic [7:0] CH_LOW_N  = 8'd110;
  localparam logic [7:0] CH_LOW_T  = 8'd116;

  // Bytes one item can cause, at most.
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned IdxW     = $clog2(MaxBytes);
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  // Entries in the queue between front and back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_SINGLE = 2'd1,
    QM_DOUBLE = 2'd2,
    QM_ELEM   = 2'd3
  } qmode_e;

  // The bytes caused by one item, with the index of the final one.
  typedef struct packed {
    logic [IdxW-1:0]               last_idx;
    logic [MaxBytes-1:0][7:0]      bytes;
  } bundle_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_HASH) || (c == CH_LT) || (c == CH_GT) || (c == CH_SLASH) ||
           (c == CH_STAR) || (c == CH_EQ) || (c == CH_LBRACK) || (c == CH_RBRACK) ||
           (c == CH_COMMA) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_DOLLAR) || is_space(c);
  endfunction

endpackage

// ===== hdl/mtt_front.sv =====
module mtt_front import mtt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_ch_i,
  input  logic       in_end_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output bundle_t    push_data_o
);

  logic [7:0] prev_q, prev_d;
  qmode_e     qmode_q, qmode_d;
  logic       tok_q, tok_d;
  logic       held_q, held_d;

  qmode_e                qm1;
  logic                  esc, sp_c, sp_p, dlm, accept;
  logic [MaxBytes-1:0]   slot_en;
  logic [7:0]            slot2;
  logic [MaxBytes-1:0][7:0] slot_val;
  logic [CntW-1:0]       pos;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  always_comb begin
    esc  = (prev_q == CH_BSLASH);
    sp_c = is_space(in_ch_i);
    sp_p = is_space(prev_q);
    dlm  = is_delim(in_ch_i);

    // Quote tracking ahead of the delimiter test.
    qm1 = qmode_q;
    if (!esc) begin
      priority if (in_ch_i == CH_SQUOTE) begin
        if (qmode_q == QM_NONE) qm1 = QM_SINGLE;
        else if (qmode_q == QM_SINGLE) qm1 = QM_NONE;
      end else if (in_ch_i == CH_DQUOTE) begin
        if (qmode_q == QM_NONE) qm1 = QM_DOUBLE;
        else if (qmode_q == QM_DOUBLE) qm1 = QM_NONE;
      end else if (in_ch_i == CH_LT) begin
        if (qmode_q == QM_ELEM) qm1 = QM_NONE;
      end else begin
        // Any other character leaves the quote mode alone.
      end
    end

    // Slot order: held backslash, token terminator, character, terminator.
    slot_en = '0;
    slot2   = in_ch_i;
    prev_d  = in_ch_i;
    qmode_d = qm1;
    tok_d   = tok_q;
    held_d  = held_q;

    priority if (in_end_i) begin
      slot_en[0] = held_q;
      slot_en[1] = 1'b1;
      prev_d     = CH_SPACE;
      qmode_d    = QM_NONE;
      tok_d      = 1'b0;
      held_d     = 1'b0;
    end else if (sp_c && sp_p) begin
      // Repeated whitespace is dropped.
    end else if (dlm && (qm1 == QM_NONE)) begin
      slot_en[0] = held_q;
      slot_en[1] = tok_q;
      slot_en[2] = !sp_c;
      slot_en[3] = !sp_c;
      held_d     = 1'b0;
      tok_d      = 1'b0;
    end else if (!sp_c || ((qm1 != QM_NONE) && (in_ch_i != CH_LF))) begin
      if (esc) begin
        priority if (in_ch_i == CH_LOW_N) begin
          slot_en[2] = held_q;
          slot2      = CH_LF;
          held_d     = 1'b0;
        end else if (in_ch_i == CH_LOW_T) begin
          slot_en[2] = held_q;
          slot2      = CH_TAB;
          held_d     = 1'b0;
        end else if (in_ch_i != CH_BSLASH) begin
          slot_en[0] = held_q;
          held_d     = 1'b0;
        end else begin
          // A further backslash is dropped and the hold stays.
        end
      end else begin
        slot_en[0] = held_q;
        if (in_ch_i == CH_BSLASH) begin
          held_d = 1'b1;
        end else begin
          slot_en[2] = 1'b1;
          held_d     = 1'b0;
        end
        tok_d = 1'b1;
      end
    end else begin
      slot_en[0] = held_q;
      held_d     = 1'b0;
    end

    if (!in_end_i && (in_ch_i == CH_GT) && !esc && (qm1 == QM_NONE)) qmode_d = QM_ELEM;

    slot_val[0] = CH_BSLASH;
    slot_val[1] = CH_NUL;
    slot_val[2] = slot2;
    slot_val[3] = CH_NUL;

    // Pack the enabled slots from the bottom.
    pos               = '0;
    push_data_o.bytes = '0;
    for (int k = 0; k < MaxBytes; k++) begin
      if (slot_en[k]) begin
        push_data_o.bytes[pos[IdxW-1:0]] = slot_val[k];
        pos = pos + CntW'(1);
      end
    end
    push_data_o.last_idx = pos[IdxW-1:0] - IdxW'(1);
    push_valid_o         = in_valid_i && (|slot_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= CH_SPACE;
      qmode_q <= QM_NONE;
      tok_q   <= 1'b0;
      held_q  <= 1'b0;
    end else if (accept) begin
      prev_q  <= prev_d;
      qmode_q <= qmode_d;
      tok_q   <= tok_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== hdl/mtt_queue.sv =====
module mtt_queue import mtt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  bundle_t push_data_i,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output bundle_t pop_data_o
);

  bundle_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPtrW'(1);
      if (do_pop)  rd_q <= rd_q + QPtrW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + QCntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QCntW'(1);
    end
  end

endmodule

// ===== hdl/mtt_back.sv =====
module mtt_back import mtt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  bundle_t    pop_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  bundle_t         cur_q, cur_d;
  logic            cur_valid_q, cur_valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            fire, at_last, load;

  assign out_valid_o = cur_valid_q;
  assign out_byte_o  = cur_q.bytes[idx_q];
  assign at_last     = (idx_q == cur_q.last_idx);
  assign out_last_o  = at_last;
  assign fire        = cur_valid_q && out_ready_i;
  // A new bundle comes in when the stage is empty or its final byte leaves.
  assign load        = !cur_valid_q || (fire && at_last);
  assign pop_ready_o = load;

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (load) begin
      cur_valid_d = pop_valid_i;
      cur_d       = pop_data_i;
      idx_d       = '0;
    end else if (fire) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

endmodule

// ===== hdl/markup_text_tokenizer.sv =====
// Channel   Direction  tdata                  tuser   tlast
// s_axis    in         [7:0] ch               none    end_of_input
// m_axis    out        [7:0] out_byte         none    last
//
// An item enters every cycle while the queue has room; an item is classified
// in the cycle it is accepted and leaves zero to four bytes in the queue.
// The back end sends one byte per cycle while m_axis_tready is high; bytes pass
// from the queue into the back-end output register before they are offered.
// Reset is asynchronous and active low and returns the tokenizer state to a
// space as previous character, no quote, no open token and no held backslash.
// A stalled output fills the four-entry queue, after which s_axis_tready drops.
module markup_text_tokenizer import mtt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic       s_axis_tlast,   // end_of_input
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // last byte caused by one input item
);

  // Front to queue.
  logic    push_valid, push_ready;
  bundle_t push_data;

  // Queue to back.
  logic    pop_valid, pop_ready;
  bundle_t pop_data;

  // The front tracks quoting, escapes and token boundaries and turns each item
  // into a packed group of output bytes.
  mtt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_ch_i      (s_axis_tdata),
    .in_end_i     (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // The queue decouples classification from byte delivery, so that a stall on
  // the output does not stop the front until the queue is full.
  mtt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // The back end serializes each group, one byte per cycle while m_axis_tready
  // is high, and marks the final byte of each group with tlast.
  mtt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== hdl/mtt_checker.sv =====
module mtt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // Nothing is offered on the output right after reset.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // A stalled output item holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output item changed");

  // An end marker always produces bytes; with an idle output they pass through
  // the queue and the back-end register and are then offered.
  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) ##1 !m_axis_tvalid |=> m_axis_tvalid)
    else $error("end marker produced no output");

  // With the output idle and no input taken, the queue is empty and the input
  // must be ready.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid && $past(!m_axis_tvalid) && $past(!(s_axis_tvalid && s_axis_tready)))
      |-> s_axis_tready)
    else $error("input stalled while block is drained");

endmodule

bind markup_text_tokenizer mtt_checker u_mtt_checker (.*);
